// ----- sv/dllm_pkg.sv -----
package dllm_pkg;

  // fixed field widths
  localparam int NODE_W = 8;
  localparam int LINK_W = 9;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [LINK_W-1:0] link_t;

  // link value for no node
  localparam link_t NONE_LINK = 9'd256;

  // write slots per operation
  localparam int SLOTS = 3;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT     = 3'd2,
    OP_REMOVE     = 3'd3,
    OP_BRING      = 3'd4,
    OP_ROTATE     = 3'd5,
    OP_READ       = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WR,
    ST_DONE
  } state_t;

  // the writes to the two link memories in one write slot
  typedef struct packed {
    logic  pv_en;
    node_t pv_addr;
    link_t pv_data;
    logic  nx_en;
    node_t nx_addr;
    link_t nx_data;
  } wr_slot_t;

  // one result, lowest field last
  typedef struct packed {
    link_t nnext;
    link_t nprev;
    link_t count;
    link_t tail;
    link_t head;
    logic  status;
  } res_t;

endpackage

// ----- sv/doubly_linked_list_manager.sv -----
// channel  direction  tdata fields (lowest bit up)            transaction
// in_      slave      operation[2:0] node[10:3] position[19:11]  tvalid && tready
// out_     master     status[0] head_node[9:1] tail_node[18:10]  tvalid && tready
//                     count[27:19] node_prev[36:28] node_next[45:37]
//
// an operation reads the links at acceptance, works out the new ones in the calculation state,
// then writes its slots (0 to 3) one after another, as each link memory has a single write port
// reads, ignored operations and moves of the head write no slot; bring to front writes all of them
// synchronous active-low reset clears head, tail, count and the linked bits, not the links
// a result waits in the output register; a stalled output blocks only the next completion
module doubly_linked_list_manager #(
  parameter int NODE_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // operation, node, position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status, head_node, tail_node, count, node_prev, node_next
);
  import dllm_pkg::*;

  localparam int DEPTH = (NODE_COUNT < 256) ? NODE_COUNT : 256;
  localparam int AW    = $clog2(DEPTH);

  // link memories and linked bits
  link_t prev_mem [DEPTH];
  link_t next_mem [DEPTH];
  logic [DEPTH-1:0] mark_r, mark_nxt;

  state_t state_r, state_nxt;

  op_t    op_r;
  node_t  x_r;
  link_t  pos_r;
  logic   bad_r;
  logic   xlnk_r;
  link_t  head_r, head_nxt;
  link_t  tail_r, tail_nxt;
  link_t  cnt_r, cnt_nxt;
  link_t  prd_r, nrd_r;

  wr_slot_t plan_r [SLOTS];
  wr_slot_t calc_plan [SLOTS];
  logic [1:0] nwr_r, calc_nwr;
  logic [1:0] wr_idx_r;

  res_t  res_r, calc_res;
  res_t  out_res_r;
  logic  out_valid_r;

  // input fields
  op_t   in_op;
  node_t in_node;
  link_t in_pos;
  logic  in_acc;
  logic  x_in_pool, p_in_pool, x_mk, p_mk, bad_c;
  logic [AW-1:0] rd_paddr, rd_naddr;

  logic out_free, out_load, wr_last;
  wr_slot_t cur_slot;
  logic wr_active;

  assign in_op   = op_t'(in_tdata[2:0]);
  assign in_node = in_tdata[10:3];
  assign in_pos  = in_tdata[19:11];
  assign in_acc  = in_tvalid && in_tready;

  // misuse checks at acceptance
  always_comb begin
    x_in_pool = (32'(in_node) < DEPTH);
    p_in_pool = (32'(in_pos) < DEPTH);
    x_mk = x_in_pool && mark_r[in_node[AW-1:0]];
    p_mk = p_in_pool && mark_r[in_pos[AW-1:0]];
    case (in_op)
      OP_PUSH_FRONT, OP_PUSH_BACK: bad_c = x_mk;
      OP_INSERT:                   bad_c = x_mk || ((in_pos != NONE_LINK) && !p_mk);
      OP_REMOVE, OP_BRING, OP_ROTATE: bad_c = !x_mk;
      OP_READ:                     bad_c = 1'b0;
      default:                     bad_c = 1'b1;
    endcase
    if (!x_in_pool) bad_c = 1'b1;
  end

  // read addresses: insert reads the predecessor of the position
  always_comb begin
    rd_naddr = x_in_pool ? in_node[AW-1:0] : '0;
    if (in_op == OP_INSERT && !bad_c && in_pos != NONE_LINK) begin
      rd_paddr = in_pos[AW-1:0];
    end else begin
      rd_paddr = rd_naddr;
    end
  end

  // new links, list registers and result from the read data
  always_comb begin
    for (int k = 0; k < SLOTS; k++) calc_plan[k] = '0;
    calc_nwr = 2'd0;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    mark_nxt = mark_r;
    calc_res.status = bad_r;
    calc_res.nprev  = xlnk_r ? prd_r : NONE_LINK;
    calc_res.nnext  = xlnk_r ? nrd_r : NONE_LINK;
    if (!bad_r) begin
      case (op_r)
        OP_PUSH_FRONT: begin
          mark_nxt[x_r[AW-1:0]] = 1'b1;
          calc_plan[0] = '{1'b1, x_r, NONE_LINK, 1'b1, x_r, head_r};
          calc_res.nprev = NONE_LINK;
          calc_res.nnext = head_r;
          head_nxt = {1'b0, x_r};
          if (head_r == NONE_LINK) begin
            tail_nxt = {1'b0, x_r};
            cnt_nxt  = 9'd1;
            calc_nwr = 2'd1;
          end else begin
            calc_plan[1] = '{1'b1, head_r[NODE_W-1:0], {1'b0, x_r}, 1'b0, '0, '0};
            cnt_nxt  = cnt_r + 9'd1;
            calc_nwr = 2'd2;
          end
        end
        OP_PUSH_BACK, OP_INSERT: begin
          mark_nxt[x_r[AW-1:0]] = 1'b1;
          cnt_nxt = cnt_r + 9'd1;
          if (op_r == OP_PUSH_BACK || pos_r == NONE_LINK) begin
            // append at the tail
            calc_plan[0] = '{1'b1, x_r, tail_r, 1'b1, x_r, NONE_LINK};
            calc_res.nprev = tail_r;
            calc_res.nnext = NONE_LINK;
            tail_nxt = {1'b0, x_r};
            if (tail_r == NONE_LINK) begin
              head_nxt = {1'b0, x_r};
              cnt_nxt  = 9'd1;
              calc_nwr = 2'd1;
            end else begin
              calc_plan[1] = '{1'b0, '0, '0, 1'b1, tail_r[NODE_W-1:0], {1'b0, x_r}};
              calc_nwr = 2'd2;
            end
          end else if (pos_r == head_r) begin
            // insert before the head
            calc_plan[0] = '{1'b1, x_r, NONE_LINK, 1'b1, x_r, pos_r};
            calc_plan[1] = '{1'b1, pos_r[NODE_W-1:0], {1'b0, x_r}, 1'b0, '0, '0};
            calc_res.nprev = NONE_LINK;
            calc_res.nnext = pos_r;
            head_nxt = {1'b0, x_r};
            calc_nwr = 2'd2;
          end else begin
            // insert between the position and its predecessor
            calc_plan[0] = '{1'b1, x_r, prd_r, 1'b1, x_r, pos_r};
            calc_plan[1] = '{1'b1, pos_r[NODE_W-1:0], {1'b0, x_r},
                             1'b1, prd_r[NODE_W-1:0], {1'b0, x_r}};
            calc_res.nprev = prd_r;
            calc_res.nnext = pos_r;
            calc_nwr = 2'd2;
          end
        end
        OP_REMOVE: begin
          mark_nxt[x_r[AW-1:0]] = 1'b0;
          calc_res.nprev = NONE_LINK;
          calc_res.nnext = NONE_LINK;
          cnt_nxt = cnt_r - 9'd1;
          if (head_r == {1'b0, x_r} && tail_r == {1'b0, x_r}) begin
            head_nxt = NONE_LINK;
            tail_nxt = NONE_LINK;
          end else if (head_r == {1'b0, x_r}) begin
            calc_plan[0] = '{1'b1, nrd_r[NODE_W-1:0], NONE_LINK, 1'b0, '0, '0};
            head_nxt = nrd_r;
            calc_nwr = 2'd1;
          end else if (tail_r == {1'b0, x_r}) begin
            calc_plan[0] = '{1'b0, '0, '0, 1'b1, prd_r[NODE_W-1:0], NONE_LINK};
            tail_nxt = prd_r;
            calc_nwr = 2'd1;
          end else begin
            calc_plan[0] = '{1'b1, nrd_r[NODE_W-1:0], prd_r,
                             1'b1, prd_r[NODE_W-1:0], nrd_r};
            calc_nwr = 2'd1;
          end
        end
        OP_BRING: begin
          if (head_r != {1'b0, x_r}) begin
            // unlink, then put in front of the old head
            calc_plan[0] = '{nrd_r != NONE_LINK, nrd_r[NODE_W-1:0], prd_r,
                             1'b1, prd_r[NODE_W-1:0], nrd_r};
            calc_plan[1] = '{1'b1, x_r, NONE_LINK, 1'b1, x_r, head_r};
            calc_plan[2] = '{1'b1, head_r[NODE_W-1:0], {1'b0, x_r}, 1'b0, '0, '0};
            if (nrd_r == NONE_LINK) tail_nxt = prd_r;
            head_nxt = {1'b0, x_r};
            calc_res.nprev = NONE_LINK;
            calc_res.nnext = head_r;
            calc_nwr = 2'd3;
          end
        end
        OP_ROTATE: begin
          if (head_r != {1'b0, x_r}) begin
            // cut before the node, join old tail to old head
            calc_plan[0] = '{1'b1, x_r, NONE_LINK, 1'b1, prd_r[NODE_W-1:0], NONE_LINK};
            calc_plan[1] = '{1'b1, head_r[NODE_W-1:0], tail_r,
                             1'b1, tail_r[NODE_W-1:0], head_r};
            tail_nxt = prd_r;
            head_nxt = {1'b0, x_r};
            calc_res.nprev = NONE_LINK;
            calc_res.nnext = (tail_r == {1'b0, x_r}) ? head_r : nrd_r;
            calc_nwr = 2'd2;
          end
        end
        default: begin
        end
      endcase
    end
    calc_res.head  = head_nxt;
    calc_res.tail  = tail_nxt;
    calc_res.count = cnt_nxt;
  end

  assign out_free = !out_valid_r || out_tready;
  assign wr_last  = (wr_idx_r == nwr_r - 2'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CALC;
      ST_CALC: begin
        if (calc_nwr != 2'd0)  state_nxt = ST_WR;
        else if (out_free)     state_nxt = ST_IDLE;
        else                   state_nxt = ST_DONE;
      end
      ST_WR: begin
        if (wr_last) state_nxt = out_free ? ST_IDLE : ST_DONE;
      end
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    wr_active = (state_r == ST_WR);
    out_load  = 1'b0;
    case (state_r)
      ST_CALC: out_load = (calc_nwr == 2'd0) && out_free;
      ST_WR:   out_load = wr_last && out_free;
      ST_DONE: out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  assign cur_slot   = plan_r[wr_idx_r];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

  // link memories: registered read at acceptance, slot writes
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prd_r <= prev_mem[rd_paddr];
      nrd_r <= next_mem[rd_naddr];
    end
    if (wr_active && cur_slot.pv_en) prev_mem[cur_slot.pv_addr[AW-1:0]] <= cur_slot.pv_data;
    if (wr_active && cur_slot.nx_en) next_mem[cur_slot.nx_addr[AW-1:0]] <= cur_slot.nx_data;
  end

  // control and list registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mark_r      <= '0;
      head_r      <= NONE_LINK;
      tail_r      <= NONE_LINK;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      wr_idx_r    <= '0;
      nwr_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CALC) begin
        mark_r   <= mark_nxt;
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        cnt_r    <= cnt_nxt;
        nwr_r    <= calc_nwr;
        wr_idx_r <= '0;
      end else if (wr_active) begin
        wr_idx_r <= wr_idx_r + 2'd1;
      end
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      x_r    <= in_node;
      pos_r  <= in_pos;
      bad_r  <= bad_c;
      xlnk_r <= x_mk;
    end
    if (state_r == ST_CALC) begin
      res_r <= calc_res;
      for (int k = 0; k < SLOTS; k++) plan_r[k] <= calc_plan[k];
    end
    if (out_load) out_res_r <= (state_r == ST_CALC) ? calc_res : res_r;
  end

`ifndef ASSERT_OFF
  // empty list has no head, no tail and zero count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ((head_r == NONE_LINK) == (cnt_r == 9'd0)) && ((tail_r == NONE_LINK) == (cnt_r == 9'd0)))
    else $error("head, tail and count disagree on empty list");

  // an accepted transaction is worked out in the next cycle
  a_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_CALC))
    else $error("accepted transaction not followed by calculation");

  // list registers change only after a calculation cycle
  a_change: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r != $past(cnt_r)) || (head_r != $past(head_r))) |-> ($past(state_r) == ST_CALC))
    else $error("list registers changed outside calculation");

  // ignored operation leaves the list untouched
  a_misuse: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC && bad_r) |=>
      (cnt_r == $past(cnt_r)) && (head_r == $past(head_r)) && (tail_r == $past(tail_r)))
    else $error("ignored operation changed the list");
`endif

endmodule

// ----- tb/doubly_linked_list_manager_test.sv -----
`timescale 1ns / 100ps

module doubly_linked_list_manager_test;
  import dllm_pkg::*;

  localparam int POOL = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // what one result transaction should carry
  typedef struct {
    logic  status;
    link_t head;
    link_t tail;
    link_t count;
    link_t nprev;
    link_t nnext;
  } list_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // operation[2:0] node[10:3] position[19:11]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // status head_node tail_node count node_prev node_next

  // predicted list state
  link_t prev_link [POOL];
  link_t next_link [POOL];
  bit    linked [POOL];
  link_t head_idx = NONE_LINK;
  link_t tail_idx = NONE_LINK;
  link_t linked_total = '0;

  list_report_t expected_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;

  doubly_linked_list_manager dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // link writes that skip the none index
  function automatic void write_prev(link_t i, link_t v);
    if (i < POOL) prev_link[i[7:0]] = v;
  endfunction

  function automatic void write_next(link_t i, link_t v);
    if (i < POOL) next_link[i[7:0]] = v;
  endfunction

  function automatic link_t read_prev(link_t i);
    return (i < POOL) ? prev_link[i[7:0]] : NONE_LINK;
  endfunction

  function automatic link_t read_next(link_t i);
    return (i < POOL) ? next_link[i[7:0]] : NONE_LINK;
  endfunction

  function automatic void link_at_tail(link_t x);
    if (tail_idx == NONE_LINK) begin
      write_prev(x, NONE_LINK);
      write_next(x, NONE_LINK);
      head_idx = x;
      tail_idx = x;
      linked_total = 9'd1;
    end else begin
      write_next(tail_idx, x);
      write_prev(x, tail_idx);
      write_next(x, NONE_LINK);
      tail_idx = x;
      linked_total++;
    end
    linked[x[7:0]] = 1'b1;
  endfunction

  function automatic void link_at_head(link_t x);
    if (head_idx == NONE_LINK) begin
      write_prev(x, NONE_LINK);
      write_next(x, NONE_LINK);
      head_idx = x;
      tail_idx = x;
      linked_total = 9'd1;
    end else begin
      write_prev(x, NONE_LINK);
      write_next(x, head_idx);
      write_prev(head_idx, x);
      head_idx = x;
      linked_total++;
    end
    linked[x[7:0]] = 1'b1;
  endfunction

  function automatic void link_before(link_t pos, link_t x);
    link_t pp;
    if (pos == head_idx) begin
      write_prev(x, NONE_LINK);
      write_next(x, pos);
      write_prev(pos, x);
      head_idx = x;
    end else begin
      pp = read_prev(pos);
      write_prev(x, pp);
      write_next(x, pos);
      write_next(pp, x);
      write_prev(pos, x);
    end
    linked_total++;
    linked[x[7:0]] = 1'b1;
  endfunction

  function automatic void unlink(link_t x);
    link_t p;
    link_t n;
    p = read_prev(x);
    n = read_next(x);
    if (head_idx == x) begin
      if (tail_idx == x) begin
        head_idx = NONE_LINK;
        tail_idx = NONE_LINK;
        linked_total = '0;
      end else begin
        write_prev(n, NONE_LINK);
        head_idx = n;
        linked_total--;
      end
    end else if (tail_idx == x) begin
      write_next(p, NONE_LINK);
      tail_idx = p;
      linked_total--;
    end else begin
      write_next(p, n);
      write_prev(n, p);
      linked_total--;
    end
    write_prev(x, NONE_LINK);
    write_next(x, NONE_LINK);
    linked[x[7:0]] = 1'b0;
  endfunction

  // move-to-front
  function automatic void move_to_head(link_t x);
    link_t p;
    link_t n;
    if (head_idx == x) return;
    p = read_prev(x);
    n = read_next(x);
    if (n == NONE_LINK) tail_idx = p;
    else write_prev(n, p);
    write_next(p, n);
    write_prev(x, NONE_LINK);
    write_next(x, head_idx);
    write_prev(head_idx, x);
    head_idx = x;
  endfunction

  // the run from s to the tail goes in front of the old head
  function automatic void rotate_run(link_t s);
    link_t old_tail;
    if (s == head_idx) return;
    old_tail = tail_idx;
    tail_idx = read_prev(s);
    write_next(tail_idx, NONE_LINK);
    write_prev(s, NONE_LINK);
    write_next(old_tail, head_idx);
    write_prev(head_idx, old_tail);
    head_idx = s;
  endfunction

  // applies one operation to the predicted list and gives the expected result
  function automatic list_report_t apply_list_op(logic [2:0] op, node_t node, link_t pos);
    list_report_t r;
    link_t x;
    logic misuse;
    x = {1'b0, node};
    misuse = 1'b0;
    case (op)
      OP_PUSH_FRONT: if (linked[node]) misuse = 1'b1; else link_at_head(x);
      OP_PUSH_BACK:  if (linked[node]) misuse = 1'b1; else link_at_tail(x);
      OP_INSERT: begin
        if (linked[node]) misuse = 1'b1;
        else if (pos == NONE_LINK) link_at_tail(x);
        else if (pos >= POOL || !linked[pos[7:0]]) misuse = 1'b1;
        else link_before(pos, x);
      end
      OP_REMOVE: if (!linked[node]) misuse = 1'b1; else unlink(x);
      OP_BRING:  if (!linked[node]) misuse = 1'b1; else move_to_head(x);
      OP_ROTATE: if (!linked[node]) misuse = 1'b1; else rotate_run(x);
      OP_READ: ;
      default: misuse = 1'b1;
    endcase
    r.status = misuse;
    r.head = head_idx;
    r.tail = tail_idx;
    r.count = linked_total;
    r.nprev = linked[node] ? prev_link[node] : NONE_LINK;
    r.nnext = linked[node] ? next_link[node] : NONE_LINK;
    return r;
  endfunction

  function automatic node_t pick_linked();
    int start;
    start = $urandom_range(POOL - 1);
    for (int k = 0; k < POOL; k++)
      if (linked[(start + k) % POOL]) return node_t'((start + k) % POOL);
    return node_t'(start);
  endfunction

  function automatic node_t pick_unlinked();
    int start;
    start = $urandom_range(POOL - 1);
    for (int k = 0; k < POOL; k++)
      if (!linked[(start + k) % POOL]) return node_t'((start + k) % POOL);
    return node_t'(start);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0d] %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // offer one operation, predict it on acceptance; tvalid stays high afterwards
  task automatic send_item(input logic [2:0] op, input node_t node, input link_t pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, pos, node, op};
    do @(posedge clk); while (!in_tready);
    expected_results.insert(expected_results.size(), apply_list_op(op, node, pos));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // mostly well-formed operations on live nodes, some raw noise
  task automatic send_random_item(input int target);
    int r;
    int insert_pct;
    logic [2:0] op;
    node_t node;
    link_t pos;
    pos = NONE_LINK;
    r = $urandom_range(99);
    if (r >= 85) begin
      op = 3'($urandom_range(7));
      node = 8'($urandom_range(255));
      pos = 9'($urandom_range(511));
    end else begin
      insert_pct = (linked_total < target) ? 60 : 25;
      if (linked_total == 0 || $urandom_range(99) < insert_pct) begin
        op = 3'($urandom_range(2));
        node = pick_unlinked();
        if (op == OP_INSERT && linked_total != 0 && $urandom_range(99) < 85)
          pos = {1'b0, pick_linked()};
      end else begin
        r = $urandom_range(99);
        op = (r < 35) ? OP_REMOVE : (r < 60) ? OP_BRING : (r < 85) ? OP_ROTATE : OP_READ;
        node = (op == OP_READ && $urandom_range(3) == 0) ? pick_unlinked() : pick_linked();
      end
    end
    send_item(op, node, pos);
  endtask

  task automatic run_directed_ops();
    // empty list: read, remove and moves of an unlinked node
    send_item(OP_READ, 8'd5, NONE_LINK);
    send_item(OP_REMOVE, 8'd5, NONE_LINK);
    send_item(OP_BRING, 8'd5, NONE_LINK);
    send_item(OP_ROTATE, 8'd5, NONE_LINK);
    // build 64 0 255 32 128 from both ends of the index range
    send_item(OP_PUSH_FRONT, 8'd0, NONE_LINK);
    send_item(OP_PUSH_BACK, 8'd255, NONE_LINK);
    send_item(OP_INSERT, 8'd128, NONE_LINK);
    send_item(OP_INSERT, 8'd64, 9'd0);
    send_item(OP_INSERT, 8'd32, 9'd128);
    // positions out of the pool or unlinked, inserts of linked nodes
    send_item(OP_INSERT, 8'd7, 9'd300);
    send_item(OP_INSERT, 8'd7, 9'd511);
    send_item(OP_INSERT, 8'd7, 9'd9);
    send_item(OP_PUSH_FRONT, 8'd255, NONE_LINK);
    send_item(OP_PUSH_BACK, 8'd0, NONE_LINK);
    send_item(OP_INSERT, 8'd32, 9'd0);
    // move-to-front of head, tail and a middle node
    send_item(OP_BRING, 8'd64, NONE_LINK);
    send_item(OP_BRING, 8'd128, NONE_LINK);
    send_item(OP_BRING, 8'd255, NONE_LINK);
    // rotations from head, tail and middle
    send_item(OP_ROTATE, head_idx[7:0], NONE_LINK);
    send_item(OP_ROTATE, tail_idx[7:0], NONE_LINK);
    send_item(OP_ROTATE, next_link[head_idx[7:0]][7:0], NONE_LINK);
    send_item(OP_READ, 8'd32, NONE_LINK);
    send_item(OP_UNUSED, 8'd0, 9'd511);
    // removes of head, tail, middle, then the rest down to empty
    send_item(OP_REMOVE, head_idx[7:0], NONE_LINK);
    send_item(OP_REMOVE, tail_idx[7:0], NONE_LINK);
    send_item(OP_REMOVE, next_link[head_idx[7:0]][7:0], NONE_LINK);
    while (linked_total != 0) send_item(OP_REMOVE, pick_linked(), NONE_LINK);
  endtask

  task automatic run_random_traffic(input int items, input int target);
    repeat (items) send_random_item(target);
  endtask

  // long receiver hold-off while operations keep coming
  task automatic run_output_stall();
    hold_requests++;
    repeat (40) send_random_item(20);
  endtask

  // every node linked, misuse, moves and a read on a full pool, then a few removes
  task automatic run_pool_fill();
    logic [2:0] op;
    while (linked_total < POOL) begin
      op = 3'($urandom_range(2));
      send_item(op, pick_unlinked(),
                (op == OP_INSERT && linked_total != 0) ? {1'b0, pick_linked()} : NONE_LINK);
    end
    send_item(OP_PUSH_FRONT, pick_linked(), NONE_LINK);
    send_item(OP_INSERT, pick_linked(), NONE_LINK);
    send_item(OP_BRING, tail_idx[7:0], NONE_LINK);
    send_item(OP_ROTATE, tail_idx[7:0], NONE_LINK);
    send_item(OP_ROTATE, pick_linked(), NONE_LINK);
    send_item(OP_READ, pick_linked(), NONE_LINK);
    while (linked_total > 240) send_item(OP_REMOVE, pick_linked(), NONE_LINK);
  endtask

  // receiver side: random idling plus requested hold-offs
  int hold_left = 0;
  int hold_served = 0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    list_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with no expectation waiting");
      end else begin
        want = expected_results.pop_front();
        compare_field("status", int'(out_tdata[0]), int'(want.status));
        compare_field("head_node", int'(out_tdata[9:1]), int'(want.head));
        compare_field("tail_node", int'(out_tdata[18:10]), int'(want.tail));
        compare_field("count", int'(out_tdata[27:19]), int'(want.count));
        compare_field("node_prev", int'(out_tdata[36:28]), int'(want.nprev));
        compare_field("node_next", int'(out_tdata[45:37]), int'(want.nnext));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // test sequence
  initial begin
    for (int i = 0; i < POOL; i++) begin
      prev_link[i] = NONE_LINK;
      next_link[i] = NONE_LINK;
      linked[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 83;
    run_directed_ops();
    run_random_traffic(80, 12);
    wait_drained();

    send_idle_pct = 83;
    recv_idle_pct = 13;
    run_output_stall();
    run_random_traffic(60, 40);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_pool_fill();
    run_random_traffic(60, 6);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- doubly_linked_list_manager.f -----
sv/dllm_pkg.sv
sv/doubly_linked_list_manager.sv
tb/doubly_linked_list_manager_test.sv
